### src/srec_pkg.sv
// shared types, result codes and decode functions for the s-record segmenter
package srec_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_FILE  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  segment_index;
    logic [31:0] byte_length;
    logic [31:0] crc_value;
    logic        last;
  } result_t;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [7:0]  CH_S     = 8'h53;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_ONE   = 8'h31;
  localparam logic [7:0]  CH_THREE = 8'h33;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c inside {[8'd48:8'd57]}) begin
      n = c[3:0];
    end else if (c inside {[8'd65:8'd70], [8'd97:8'd102]}) begin
      n = c[3:0] + 4'd9;
    end
    return n;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/srec_outq.sv
// three-entry result queue that takes up to two results per item
module srec_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  srec_pkg::result_t push0,
  input  srec_pkg::result_t push1,
  output logic              room,
  output logic              head_valid,
  input  logic              head_ready,
  output srec_pkg::result_t head
);

  localparam int Depth = 3;

  srec_pkg::result_t q_r   [Depth];
  srec_pkg::result_t q_nxt [Depth];
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  logic              pop;
  logic [1:0]        kept;

  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[0];
  assign pop        = head_valid && head_ready;
  assign kept       = cnt_r - {1'b0, pop};
  assign room       = (kept <= 2'd1);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push_cnt != 2'd0 && 2'(i) == kept) begin
        q_nxt[i] = push0;
      end else if (push_cnt == 2'd2 && 2'(i) == kept + 2'd1) begin
        q_nxt[i] = push1;
      end
    end
    cnt_nxt = kept + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    for (int i = 0; i < Depth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

### src/srec_stream_segmenter_crc32.sv
// top level: s-record parser that emits data bytes, segment summaries and a file summary
// Takes one character per cycle and decodes it in a single pass: every accepted
// character updates the parser, address and CRC-32 registers in the same cycle and
// pushes zero, one or two results into a three-entry result queue. A data byte or a
// segment close gives one result; only the file finish that also closes an
// open segment gives two results, which the queue drains in order. in_tready
// stays high as long as the queue can still take two results after this cycle's pop,
// so with the output side always ready the block sustains one character per cycle.
// Once the file is finished every further item is taken and ignored until reset.
module srec_stream_segmenter_crc32 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // ch
  input  logic          in_tlast,   // end_of_input
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // address, data_byte, segment_index, byte_length, crc_value
  output logic [1:0]    out_tuser,  // kind
  output logic          out_tlast   // last
);

  typedef enum logic [2:0] {
    PH_LINE, PH_TYPE, PH_COUNT, PH_ADDR, PH_DATA, PH_SKIP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  dleft_r, dleft_nxt;
  logic [7:0]  bleft_r, bleft_nxt;
  logic [31:0] baddr_r, baddr_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] sstart_r, sstart_nxt;
  logic [31:0] slen_r, slen_nxt;
  logic [31:0] tlen_r, tlen_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic [31:0] fcrc_r, fcrc_nxt;
  logic [7:0]  scount_r, scount_nxt;
  logic        finished_r, finished_nxt;
  logic        segopen_r, segopen_nxt;

  logic              in_fire;
  logic              room;
  logic [1:0]        push_cnt;
  srec_pkg::result_t res0, res1, close_res, file_res, head;
  logic [3:0]        nib;
  logic [31:0]       acc_sh;
  logic [3:0]        dleft_dec;
  logic [7:0]        over;
  logic [7:0]        bleft_dec;

  assign in_tready = room;
  assign in_fire   = in_tvalid && in_tready;
  assign nib       = srec_pkg::hex_nibble(in_tdata);
  assign acc_sh    = {acc_r[27:0], nib};
  assign dleft_dec = dleft_r - 4'd1;
  assign over      = {6'd0, kind_r} + 8'd2;
  assign bleft_dec = bleft_r - 8'd1;

  always_comb begin
    close_res               = '0;
    close_res.kind          = srec_pkg::KIND_CLOSE;
    close_res.address       = sstart_r;
    close_res.segment_index = scount_r - 8'd1;
    close_res.byte_length   = slen_r;
    close_res.crc_value     = ~scrc_r;
    file_res                = '0;
    file_res.kind           = srec_pkg::KIND_FILE;
    file_res.segment_index  = scount_r;
    file_res.byte_length    = tlen_r;
    file_res.crc_value      = ~fcrc_r;
    file_res.last           = 1'b1;
  end

  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    acc_nxt      = acc_r;
    dleft_nxt    = dleft_r;
    bleft_nxt    = bleft_r;
    baddr_nxt    = baddr_r;
    exp_nxt      = exp_r;
    sstart_nxt   = sstart_r;
    slen_nxt     = slen_r;
    tlen_nxt     = tlen_r;
    scrc_nxt     = scrc_r;
    fcrc_nxt     = fcrc_r;
    scount_nxt   = scount_r;
    finished_nxt = finished_r;
    segopen_nxt  = segopen_r;
    push_cnt     = 2'd0;
    res0         = '0;
    res1         = '0;

    if (in_fire && !finished_r) begin
      if (in_tlast || (phase_r == PH_LINE && in_tdata != srec_pkg::CH_S)) begin
        // file finish, closing any open segment first
        if (segopen_r) begin
          res0     = close_res;
          res1     = file_res;
          push_cnt = 2'd2;
        end else begin
          res0     = file_res;
          push_cnt = 2'd1;
        end
        segopen_nxt  = 1'b0;
        finished_nxt = 1'b1;
        phase_nxt    = PH_LINE;
      end else if (phase_r == PH_LINE) begin
        phase_nxt = PH_TYPE;
      end else if (in_tdata == srec_pkg::CH_LF) begin
        phase_nxt = PH_LINE;
      end else if (phase_r == PH_TYPE) begin
        if (in_tdata >= srec_pkg::CH_ONE && in_tdata <= srec_pkg::CH_THREE) begin
          kind_nxt  = in_tdata[1:0];
          acc_nxt   = '0;
          dleft_nxt = 4'd2;
          phase_nxt = PH_COUNT;
        end else begin
          kind_nxt  = 2'd0;
          phase_nxt = PH_SKIP;
        end
      end else if (phase_r != PH_SKIP) begin
        acc_nxt   = acc_sh;
        dleft_nxt = dleft_dec;
        if (dleft_dec == 4'd0) begin
          acc_nxt   = '0;
          dleft_nxt = 4'd2;
          case (phase_r)
            PH_COUNT: begin
              bleft_nxt = (acc_sh[7:0] > over) ? acc_sh[7:0] - over : 8'd0;
              dleft_nxt = {1'b0, kind_r, 1'b0} + 4'd2;
              phase_nxt = PH_ADDR;
            end
            PH_ADDR: begin
              baddr_nxt = acc_sh;
              if (tlen_r == 32'd0 || exp_r != acc_sh) begin
                if (segopen_r) begin
                  res0      = close_res;
                  res0.last = 1'b1;
                  push_cnt  = 2'd1;
                end
                sstart_nxt  = acc_sh;
                slen_nxt    = '0;
                scrc_nxt    = srec_pkg::CRC_INIT;
                exp_nxt     = acc_sh;
                scount_nxt  = scount_r + 8'd1;
                segopen_nxt = 1'b1;
              end
              phase_nxt = (bleft_r == 8'd0) ? PH_SKIP : PH_DATA;
            end
            default: begin
              res0.kind          = srec_pkg::KIND_DATA;
              res0.address       = baddr_r;
              res0.data_byte     = acc_sh[7:0];
              res0.segment_index = scount_r - 8'd1;
              res0.last          = 1'b1;
              push_cnt           = 2'd1;
              scrc_nxt           = srec_pkg::crc_byte(scrc_r, acc_sh[7:0]);
              fcrc_nxt           = srec_pkg::crc_byte(fcrc_r, acc_sh[7:0]);
              slen_nxt           = slen_r + 32'd1;
              tlen_nxt           = tlen_r + 32'd1;
              baddr_nxt          = baddr_r + 32'd1;
              exp_nxt            = exp_r + 32'd1;
              bleft_nxt          = bleft_dec;
              if (bleft_dec == 8'd0) begin
                phase_nxt = PH_SKIP;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LINE;
      kind_r     <= '0;
      acc_r      <= '0;
      dleft_r    <= '0;
      bleft_r    <= '0;
      baddr_r    <= '0;
      exp_r      <= '0;
      sstart_r   <= '0;
      slen_r     <= '0;
      tlen_r     <= '0;
      scrc_r     <= srec_pkg::CRC_INIT;
      fcrc_r     <= srec_pkg::CRC_INIT;
      scount_r   <= '0;
      finished_r <= 1'b0;
      segopen_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      acc_r      <= acc_nxt;
      dleft_r    <= dleft_nxt;
      bleft_r    <= bleft_nxt;
      baddr_r    <= baddr_nxt;
      exp_r      <= exp_nxt;
      sstart_r   <= sstart_nxt;
      slen_r     <= slen_nxt;
      tlen_r     <= tlen_nxt;
      scrc_r     <= scrc_nxt;
      fcrc_r     <= fcrc_nxt;
      scount_r   <= scount_nxt;
      finished_r <= finished_nxt;
      segopen_r  <= segopen_nxt;
    end
  end

  srec_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (res0),
    .push1      (res1),
    .room       (room),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  assign out_tdata = {head.crc_value, head.byte_length, head.segment_index,
                      head.data_byte, head.address};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

`ifndef SYNTHESIS
  a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag cleared without reset");

  a_no_results_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> push_cnt == 2'd0)
    else $error("result produced after file finish");

  a_data_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == srec_pkg::KIND_DATA |-> out_tlast)
    else $error("data item without last flag");

  a_file_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == srec_pkg::KIND_FILE |-> out_tlast && finished_r)
    else $error("file summary without last flag or finish");
`endif

endmodule
